### sv/beg_pkg.sv
// ----------------------------------------------------------------------------
// beg_pkg
// Shared types, constants and register codes for the battery energy gauge.
// ----------------------------------------------------------------------------
package beg_pkg;

    localparam int REG_W          = 40;
    localparam int ENERGY_WIDTH_D = 40;

    localparam int VOLT_W  = 14;
    localparam int PCUR_W  = 12;
    localparam int BCUR_W  = 13;
    localparam int PANEL_W = VOLT_W + PCUR_W + 1;
    localparam int GAIN_W  = PANEL_W + 2;
    localparam int DRAIN_W = 26;
    localparam int LANES   = 3;

    localparam logic [REG_W-1:0] FULL_RESET = 40'd64378440000;
    localparam logic [REG_W-1:0] LOW_RESET  = 40'd10800000000;
    localparam logic [REG_W-1:0] HIGH_RESET = 40'd28800000000;

    localparam logic [DRAIN_W-1:0] BUS5_MV = 26'd5000;
    localparam logic [DRAIN_W-1:0] BUS3_MV = 26'd3000;

    localparam int STAT_COMPLETE_BIT = 0;
    localparam int STAT_CHARGING_BIT = 1;

    typedef enum logic [1:0] {
        REG_FULL_CAPACITY  = 2'd0,
        REG_LOW_THRESHOLD  = 2'd1,
        REG_HIGH_THRESHOLD = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [1:0]        charge_status;
        logic [BCUR_W-1:0] bus5_current_ma;
        logic [BCUR_W-1:0] bus3_current_ma;
        logic [VOLT_W-1:0] x_voltage_mv;
        logic [PCUR_W-1:0] x_neg_current_ma;
        logic [PCUR_W-1:0] x_pos_current_ma;
        logic [VOLT_W-1:0] y_voltage_mv;
        logic [PCUR_W-1:0] y_neg_current_ma;
        logic [PCUR_W-1:0] y_pos_current_ma;
        logic [VOLT_W-1:0] z_voltage_mv;
        logic [PCUR_W-1:0] z_neg_current_ma;
        logic [PCUR_W-1:0] z_pos_current_ma;
    } sample_t;

    typedef struct packed {
        logic [REG_W-1:0] energy_uj;
        logic             low_power;
    } result_t;

    typedef struct packed {
        logic [1:0]       addr;
        logic [REG_W-1:0] wdata;
    } cfg_word_t;

    typedef struct packed {
        logic [REG_W-1:0] full_capacity_uj;
        logic [REG_W-1:0] low_threshold_uj;
        logic [REG_W-1:0] high_threshold_uj;
    } cfg_regs_t;

endpackage

### sv/beg_stream_if.sv
// ----------------------------------------------------------------------------
// beg_stream_if
// Valid/ready channel carrying one word of a given type.
// ----------------------------------------------------------------------------
interface beg_stream_if #(parameter type word_t = logic);
    logic  valid;
    logic  ready;
    word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### sv/beg_panel_lane.sv
// ----------------------------------------------------------------------------
// beg_panel_lane
// One solar panel lane: registered V * (Ineg + Ipos) in microjoules.
// ----------------------------------------------------------------------------
module beg_panel_lane (
    input  logic                        clk,
    input  logic                        en,
    input  logic [beg_pkg::VOLT_W-1:0]  voltage_mv,
    input  logic [beg_pkg::PCUR_W-1:0]  neg_current_ma,
    input  logic [beg_pkg::PCUR_W-1:0]  pos_current_ma,
    output logic [beg_pkg::PANEL_W-1:0] panel_uj
);
    import beg_pkg::*;

    logic [PCUR_W:0]    cur_sum;
    logic [PANEL_W-1:0] panel_reg;
    logic [PANEL_W-1:0] panel_next;

    assign cur_sum    = {1'b0, neg_current_ma} + {1'b0, pos_current_ma};
    assign panel_next = PANEL_W'(voltage_mv) * PANEL_W'(cur_sum);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            panel_reg <= panel_next;
        end
    end

    assign panel_uj = panel_reg;
endmodule

### sv/beg_drain_lane.sv
// ----------------------------------------------------------------------------
// beg_drain_lane
// Bus output lane: registered 5000*I5 + 3000*I3 in microjoules.
// ----------------------------------------------------------------------------
module beg_drain_lane (
    input  logic                        clk,
    input  logic                        en,
    input  logic [beg_pkg::BCUR_W-1:0]  bus5_current_ma,
    input  logic [beg_pkg::BCUR_W-1:0]  bus3_current_ma,
    output logic [beg_pkg::DRAIN_W-1:0] drain_uj
);
    import beg_pkg::*;

    logic [DRAIN_W-1:0] drain_reg;
    logic [DRAIN_W-1:0] drain_next;

    assign drain_next = BUS5_MV * DRAIN_W'(bus5_current_ma)
                      + BUS3_MV * DRAIN_W'(bus3_current_ma);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            drain_reg <= drain_next;
        end
    end

    assign drain_uj = drain_reg;
endmodule

### sv/beg_merge.sv
// ----------------------------------------------------------------------------
// beg_merge
// Merges lane results: gain sum, saturating energy update, low power flag.
// ----------------------------------------------------------------------------
module beg_merge #(
    parameter int ENERGY_WIDTH = beg_pkg::ENERGY_WIDTH_D
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  beg_pkg::cfg_regs_t          cfg_regs,
    input  logic                        lane_valid,
    output logic                        lane_ready,
    input  logic [1:0]                  lane_status,
    input  logic [beg_pkg::DRAIN_W-1:0] lane_drain,
    input  logic [beg_pkg::PANEL_W-1:0] lane_panel [beg_pkg::LANES],
    beg_stream_if.source                result
);
    import beg_pkg::*;

    localparam int EW = ENERGY_WIDTH;
    localparam int CW = (EW > REG_W) ? EW : REG_W;
    localparam logic [CW-1:0] MAX_EXT        = CW'({EW{1'b1}});
    localparam logic [CW-1:0] FULL_RESET_EXT = CW'(FULL_RESET);
    localparam logic [EW-1:0] ENERGY_MAX     = {EW{1'b1}};
    localparam logic [EW-1:0] ENERGY_RESET   =
        (FULL_RESET_EXT > MAX_EXT) ? ENERGY_MAX : EW'(FULL_RESET_EXT);

    // stage 2: merged lanes
    logic               v2_reg;
    logic [1:0]         status_reg;
    logic [GAIN_W-1:0]  gain_reg;
    logic [GAIN_W-1:0]  gain_next;
    logic [DRAIN_W-1:0] drain_reg;
    // stage 3: energy state
    logic               v3_reg;
    logic [EW-1:0]      energy_reg;
    logic [EW-1:0]      energy_next;
    // stage 4: result word
    logic               v4_reg;
    logic [REG_W-1:0]   out_energy_reg;
    logic               low_power_reg;
    logic               low_power_next;

    logic en2, en3, en4;
    logic [CW-1:0] full_ext;
    logic [EW-1:0] full_clamp;
    logic [EW-1:0] drain_ext;
    logic [EW-1:0] gain_ext;
    logic [EW-1:0] after_drain;
    logic [EW-1:0] base_energy;
    logic [CW-1:0] energy_ext;
    logic [CW-1:0] low_ext;
    logic [CW-1:0] high_ext;

    assign en4        = !v4_reg || result.ready;
    assign en3        = !v3_reg || en4;
    assign en2        = !v2_reg || en3;
    assign lane_ready = en2;

    assign gain_next = GAIN_W'(lane_panel[0]) + GAIN_W'(lane_panel[1])
                     + GAIN_W'(lane_panel[2]);

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            status_reg <= lane_status;
            gain_reg   <= gain_next;
            drain_reg  <= lane_drain;
        end
    end

    assign full_ext   = CW'(cfg_regs.full_capacity_uj);
    assign full_clamp = (full_ext > MAX_EXT) ? ENERGY_MAX : EW'(full_ext);
    assign drain_ext  = EW'(drain_reg);
    assign gain_ext   = EW'(gain_reg);

    always_comb
    begin
        after_drain = (drain_ext >= energy_reg) ? '0 : energy_reg - drain_ext;
        base_energy = status_reg[STAT_COMPLETE_BIT] ? full_clamp : after_drain;
        energy_next = base_energy;
        if (status_reg[STAT_CHARGING_BIT])
        begin
            // headroom to full scale is the complement
            energy_next = (gain_ext >= ~base_energy) ? ENERGY_MAX
                                                      : base_energy + gain_ext;
        end
    end

    assign energy_ext = CW'(energy_reg);
    assign low_ext    = CW'(cfg_regs.low_threshold_uj);
    assign high_ext   = CW'(cfg_regs.high_threshold_uj);

    always_comb
    begin
        low_power_next = low_power_reg;
        priority if (energy_ext < low_ext)
        begin
            low_power_next = 1'b1;
        end
        else if (low_power_reg && energy_ext > high_ext)
        begin
            low_power_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            energy_reg    <= ENERGY_RESET;
            low_power_reg <= 1'b0;
        end
        else
        begin
            if (en2)
            begin
                v2_reg <= lane_valid;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
                if (v2_reg)
                begin
                    energy_reg <= energy_next;
                end
            end
            if (en4)
            begin
                v4_reg <= v3_reg;
                if (v3_reg)
                begin
                    low_power_reg <= low_power_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en4 && v3_reg)
        begin
            out_energy_reg <= REG_W'(energy_reg);
        end
    end

    assign result.valid          = v4_reg;
    assign result.data.energy_uj = out_energy_reg;
    assign result.data.low_power = low_power_reg;

`ifndef SYNTHESIS
    a_energy_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(en3 && v2_reg) |=> $stable(energy_reg))
        else $error("energy changed without a word");

    a_drain_only: assert property (@(posedge clk) disable iff (!rst_n)
        (en3 && v2_reg && status_reg == 2'b00) |=> energy_reg <= $past(energy_reg))
        else $error("energy rose without charging");

    a_reload: assert property (@(posedge clk) disable iff (!rst_n)
        (en3 && v2_reg && status_reg[STAT_COMPLETE_BIT] && !status_reg[STAT_CHARGING_BIT])
        |=> energy_reg == $past(full_clamp))
        else $error("charge complete did not reload");

    a_low_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (en4 && v3_reg && energy_ext < low_ext) |=> low_power_reg)
        else $error("low power flag not set");
`endif
endmodule

### sv/battery_energy_gauge_unit.sv
// ----------------------------------------------------------------------------
// battery_energy_gauge_unit
// Energy counting gauge: panel and bus lanes in parallel, merged into a
// saturating microjoule count with a hysteretic low power flag.
//
// Channel   Dir  Word         Notes
// sample    in   sample_t     one per one-second sample
// result    out  result_t     one per sample, in order
// cfg       in   cfg_word_t   addr 0 full cap, 1 low thr, 2 high thr
//
// Four-stage pipeline: lanes, merge, energy update, result register.
// A new sample is taken every cycle while no stall on result backs up the pipeline.
// The energy register's next value is formed combinationally from its own value.
// Stalls on result collapse bubbles stage by stage.
// Reset loads full capacity into the energy and clears the flag.
// ----------------------------------------------------------------------------
module battery_energy_gauge_unit #(
    parameter int ENERGY_WIDTH = beg_pkg::ENERGY_WIDTH_D
) (
    input  logic         clk,
    input  logic         rst_n,
    beg_stream_if.sink   sample,
    beg_stream_if.source result,
    beg_stream_if.sink   cfg
);
    import beg_pkg::*;

    cfg_regs_t          cfg_regs_reg;
    logic               v1_reg;
    logic [1:0]         status1_reg;
    logic               en1;
    logic               lane_ready;
    logic [DRAIN_W-1:0] lane_drain;
    logic [PANEL_W-1:0] lane_panel [LANES];
    logic [VOLT_W-1:0]  volt     [LANES];
    logic [PCUR_W-1:0]  neg_cur  [LANES];
    logic [PCUR_W-1:0]  pos_cur  [LANES];

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_regs_reg.full_capacity_uj  <= FULL_RESET;
            cfg_regs_reg.low_threshold_uj  <= LOW_RESET;
            cfg_regs_reg.high_threshold_uj <= HIGH_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.data.addr)
                REG_FULL_CAPACITY:  cfg_regs_reg.full_capacity_uj  <= cfg.data.wdata;
                REG_LOW_THRESHOLD:  cfg_regs_reg.low_threshold_uj  <= cfg.data.wdata;
                REG_HIGH_THRESHOLD: cfg_regs_reg.high_threshold_uj <= cfg.data.wdata;
                default: ;
            endcase
        end
    end

    assign en1          = !v1_reg || lane_ready;
    assign sample.ready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en1)
        begin
            v1_reg <= sample.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            status1_reg <= sample.data.charge_status;
        end
    end

    assign volt[0]    = sample.data.x_voltage_mv;
    assign neg_cur[0] = sample.data.x_neg_current_ma;
    assign pos_cur[0] = sample.data.x_pos_current_ma;
    assign volt[1]    = sample.data.y_voltage_mv;
    assign neg_cur[1] = sample.data.y_neg_current_ma;
    assign pos_cur[1] = sample.data.y_pos_current_ma;
    assign volt[2]    = sample.data.z_voltage_mv;
    assign neg_cur[2] = sample.data.z_neg_current_ma;
    assign pos_cur[2] = sample.data.z_pos_current_ma;

    for (genvar i = 0; i < LANES; i++)
    begin : g_panel
        beg_panel_lane u_lane (
            .clk            (clk),
            .en             (en1),
            .voltage_mv     (volt[i]),
            .neg_current_ma (neg_cur[i]),
            .pos_current_ma (pos_cur[i]),
            .panel_uj       (lane_panel[i])
        );
    end

    beg_drain_lane u_drain (
        .clk             (clk),
        .en              (en1),
        .bus5_current_ma (sample.data.bus5_current_ma),
        .bus3_current_ma (sample.data.bus3_current_ma),
        .drain_uj        (lane_drain)
    );

    beg_merge #(
        .ENERGY_WIDTH (ENERGY_WIDTH)
    ) u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_regs    (cfg_regs_reg),
        .lane_valid  (v1_reg),
        .lane_ready  (lane_ready),
        .lane_status (status1_reg),
        .lane_drain  (lane_drain),
        .lane_panel  (lane_panel),
        .result      (result)
    );
endmodule

### test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the battery energy gauge against its own cycle-free prediction of
// the microjoule count and the low power flag. A short directed run covers
// reload, drain, charge, saturation and threshold edges. Random samples then
// run under several register settings, with idle gaps on the sample side
// and stalls on the result side.
// ----------------------------------------------------------------------------
module testbench;

    import beg_pkg::*;

    localparam int GAUGE_WIDTH     = ENERGY_WIDTH_D;
    localparam int SETTLE_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int RANDOM_PHASES   = 10;
    localparam int ITEMS_PER_PHASE = 115;

    localparam logic [63:0]      ENERGY_CEIL = (64'd1 << GAUGE_WIDTH) - 64'd1;
    localparam logic [REG_W-1:0] REG_ALL_ONES = '1;
    localparam logic [1:0]       REG_SPARE    = 2'd3;

    localparam logic [1:0] CHG_NONE        = 2'b00;
    localparam logic [1:0] CHG_DONE        = 2'b01;
    localparam logic [1:0] CHG_ACTIVE      = 2'b10;
    localparam logic [1:0] CHG_DONE_ACTIVE = 2'b11;

    typedef struct {
        sample_t word;
        bit      drain_first;
    } queued_sample_t;

    logic      clk          = 1'b0;
    logic      rst_n        = 1'b0;
    logic      sample_valid = 1'b0;
    sample_t   sample_word  = '0;
    logic      result_ready = 1'b0;
    logic      cfg_valid    = 1'b0;
    cfg_word_t cfg_word     = '0;

    beg_stream_if #(.word_t(sample_t))   sample_ch ();
    beg_stream_if #(.word_t(result_t))   result_ch ();
    beg_stream_if #(.word_t(cfg_word_t)) cfg_ch ();

    assign sample_ch.valid = sample_valid;
    assign sample_ch.data  = sample_word;
    assign result_ch.ready = result_ready;
    assign cfg_ch.valid    = cfg_valid;
    assign cfg_ch.data     = cfg_word;

    battery_energy_gauge_unit #(.ENERGY_WIDTH(GAUGE_WIDTH)) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    // gauge state as the block should hold it
    logic [REG_W-1:0] gauge_full_cap  = FULL_RESET;
    logic [REG_W-1:0] gauge_low_thr   = LOW_RESET;
    logic [REG_W-1:0] gauge_high_thr  = HIGH_RESET;
    logic [63:0]      gauge_energy    = (64'(FULL_RESET) > ENERGY_CEIL) ? ENERGY_CEIL
                                                                        : 64'(FULL_RESET);
    logic             gauge_low_power = 1'b0;

    queued_sample_t sample_backlog[$];
    result_t        expected_readings[$];

    bit      sender_idles   = 1'b1;
    bit      receiver_idles = 1'b1;
    bit      word_up        = 1'b0;
    int      gap_left       = 0;
    int      stall_left     = 0;
    int      quiet_cycles   = 0;
    int      failures       = 0;
    result_t got_reading;
    result_t want_reading;

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic logic [63:0] panel_energy(input logic [VOLT_W-1:0] mv,
                                                 input logic [PCUR_W-1:0] ineg,
                                                 input logic [PCUR_W-1:0] ipos);
        return 64'(mv) * (64'(ineg) + 64'(ipos));
    endfunction

    task automatic advance_gauge(input sample_t s);
        logic [63:0] e;
        logic [63:0] drain;
        logic [63:0] gain;
        result_t     r;
        e = gauge_energy;
        if (s.charge_status[STAT_COMPLETE_BIT])
        begin
            e = (64'(gauge_full_cap) > ENERGY_CEIL) ? ENERGY_CEIL : 64'(gauge_full_cap);
        end
        else
        begin
            drain = 64'(BUS5_MV) * 64'(s.bus5_current_ma)
                  + 64'(BUS3_MV) * 64'(s.bus3_current_ma);
            e = (drain >= e) ? 64'd0 : e - drain;
        end
        if (s.charge_status[STAT_CHARGING_BIT])
        begin
            gain = panel_energy(s.x_voltage_mv, s.x_neg_current_ma, s.x_pos_current_ma)
                 + panel_energy(s.y_voltage_mv, s.y_neg_current_ma, s.y_pos_current_ma)
                 + panel_energy(s.z_voltage_mv, s.z_neg_current_ma, s.z_pos_current_ma);
            e = (gain >= ENERGY_CEIL - e) ? ENERGY_CEIL : e + gain;
        end
        gauge_energy = e;
        if (e < 64'(gauge_low_thr))
        begin
            gauge_low_power = 1'b1;
        end
        else if (gauge_low_power && e > 64'(gauge_high_thr))
        begin
            gauge_low_power = 1'b0;
        end
        r.energy_uj = e[REG_W-1:0];
        r.low_power = gauge_low_power;
        expected_readings.push_back(r);
    endtask

    task automatic log_failure(input string what);
        failures++;
        if (failures <= 10)
        begin
            $display("ERROR at %0t: %s", $time, what);
        end
    endtask

    function automatic void push_sample(input sample_t w, input bit drain_first);
        queued_sample_t q;
        q.word        = w;
        q.drain_first = drain_first;
        sample_backlog.push_back(q);
    endfunction

    function automatic sample_t uniform_sample(input logic [1:0] status, input int bus,
                                               input int volt, input int cur);
        sample_t s;
        s.charge_status    = status;
        s.bus5_current_ma  = BCUR_W'(bus);
        s.bus3_current_ma  = BCUR_W'(bus);
        s.x_voltage_mv     = VOLT_W'(volt);
        s.y_voltage_mv     = VOLT_W'(volt);
        s.z_voltage_mv     = VOLT_W'(volt);
        s.x_neg_current_ma = PCUR_W'(cur);
        s.x_pos_current_ma = PCUR_W'(cur);
        s.y_neg_current_ma = PCUR_W'(cur);
        s.y_pos_current_ma = PCUR_W'(cur);
        s.z_neg_current_ma = PCUR_W'(cur);
        s.z_pos_current_ma = PCUR_W'(cur);
        return s;
    endfunction

    // mostly within the usual range, now and then anywhere in the field
    function automatic int span(input int field_max, input int usual_max);
        return ($urandom_range(0, 7) == 0) ? $urandom_range(0, field_max)
                                           : $urandom_range(0, usual_max);
    endfunction

    function automatic sample_t random_sample(input int charge_pct, input int pcur_ceiling);
        sample_t s;
        int      roll;
        roll = $urandom_range(0, 99);
        if (roll < 5)
            s.charge_status = CHG_DONE;
        else if (roll < 10)
            s.charge_status = CHG_DONE_ACTIVE;
        else if (roll < 10 + charge_pct)
            s.charge_status = CHG_ACTIVE;
        else
            s.charge_status = CHG_NONE;
        s.bus5_current_ma  = BCUR_W'(span(8191, 2047));
        s.bus3_current_ma  = BCUR_W'(span(8191, 2047));
        s.x_voltage_mv     = VOLT_W'($urandom_range(0, 16383));
        s.y_voltage_mv     = VOLT_W'($urandom_range(0, 16383));
        s.z_voltage_mv     = VOLT_W'($urandom_range(0, 16383));
        s.x_neg_current_ma = PCUR_W'(span(4095, pcur_ceiling));
        s.x_pos_current_ma = PCUR_W'(span(4095, pcur_ceiling));
        s.y_neg_current_ma = PCUR_W'(span(4095, pcur_ceiling));
        s.y_pos_current_ma = PCUR_W'(span(4095, pcur_ceiling));
        s.z_neg_current_ma = PCUR_W'(span(4095, pcur_ceiling));
        s.z_pos_current_ma = PCUR_W'(span(4095, pcur_ceiling));
        return s;
    endfunction

    function automatic logic [REG_W-1:0] any_reg_value();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[REG_W-1:0];
    endfunction

    task automatic write_register(input logic [1:0] idx, input logic [REG_W-1:0] value);
        cfg_word.addr  <= idx;
        cfg_word.wdata <= value;
        cfg_valid      <= 1'b1;
        @(posedge clk);
        while (!cfg_ch.ready)
        begin
            @(posedge clk);
        end
        case (idx)
            REG_FULL_CAPACITY:  gauge_full_cap = value;
            REG_LOW_THRESHOLD:  gauge_low_thr  = value;
            REG_HIGH_THRESHOLD: gauge_high_thr = value;
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic settle();
        while (sample_backlog.size() != 0 || sample_valid || expected_readings.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // sample driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            sample_valid <= 1'b0;
            word_up = 1'b0;
            gap_left = 0;
        end
        else
        begin
            if (sample_valid && sample_ch.ready)
            begin
                advance_gauge(sample_word);
                word_up = 1'b0;
                gap_left = sender_idles ? $urandom_range(0, 19) : 0;
            end
            if (!word_up && sample_backlog.size() != 0)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                end
                else if (!sample_backlog[0].drain_first || expected_readings.size() == 0)
                begin
                    sample_word <= sample_backlog[0].word;
                    void'(sample_backlog.pop_front());
                    word_up = 1'b1;
                end
            end
            sample_valid <= word_up;
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            result_ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (result_ch.valid && result_ready)
            begin
                got_reading = result_ch.data;
                if (expected_readings.size() == 0)
                begin
                    log_failure($sformatf("unexpected word energy=%0d low_power=%0b",
                                          got_reading.energy_uj, got_reading.low_power));
                end
                else
                begin
                    want_reading = expected_readings.pop_front();
                    if (got_reading.energy_uj !== want_reading.energy_uj
                        || got_reading.low_power !== want_reading.low_power)
                    begin
                        log_failure($sformatf(
                            "energy exp %0d got %0d, low_power exp %0b got %0b",
                            want_reading.energy_uj, got_reading.energy_uj,
                            want_reading.low_power, got_reading.low_power));
                    end
                end
                stall_left = receiver_idles ? $urandom_range(0, 19) : 0;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                result_ready <= 1'b0;
            end
            else
            begin
                result_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((sample_valid && sample_ch.ready) || (result_ch.valid && result_ready)
            || (cfg_valid && cfg_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        logic [63:0] full;
        logic [63:0] low;
        logic [63:0] high;
        int          charge_pct;
        int          pcur_ceiling;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: idle, heaviest drain, heaviest charge, both bits, reload
        push_sample(uniform_sample(CHG_NONE, 0, 0, 0), 1'b0);
        push_sample(uniform_sample(CHG_NONE, 8191, 16383, 4095), 1'b0);
        push_sample(uniform_sample(CHG_ACTIVE, 0, 16383, 4095), 1'b0);
        push_sample(uniform_sample(CHG_DONE_ACTIVE, 8191, 16383, 4095), 1'b0);
        push_sample(uniform_sample(CHG_DONE, 8191, 0, 0), 1'b0);
        settle();

        // thresholds equal to capacity: exercise the flag edges exactly
        write_register(REG_FULL_CAPACITY, 40'd150000000);
        write_register(REG_LOW_THRESHOLD, 40'd150000000);
        write_register(REG_HIGH_THRESHOLD, 40'd150000000);
        write_register(REG_SPARE, any_reg_value());
        push_sample(uniform_sample(CHG_DONE, 8191, 0, 0), 1'b0);
        push_sample(uniform_sample(CHG_NONE, 8191, 0, 0), 1'b0);
        push_sample(uniform_sample(CHG_DONE, 0, 0, 0), 1'b0);
        push_sample(uniform_sample(CHG_DONE_ACTIVE, 0, 1, 1), 1'b0);
        push_sample(uniform_sample(CHG_NONE, 8191, 0, 0), 1'b0);
        push_sample(uniform_sample(CHG_NONE, 8191, 0, 0), 1'b0);
        push_sample(uniform_sample(CHG_NONE, 8191, 0, 0), 1'b0);
        push_sample(uniform_sample(CHG_ACTIVE, 8191, 16383, 4095), 1'b0);
        settle();

        // full scale capacity: saturation at the top
        write_register(REG_FULL_CAPACITY, REG_ALL_ONES);
        write_register(REG_LOW_THRESHOLD, '0);
        write_register(REG_HIGH_THRESHOLD, REG_ALL_ONES);
        push_sample(uniform_sample(CHG_DONE, 0, 0, 0), 1'b0);
        push_sample(uniform_sample(CHG_ACTIVE, 0, 16383, 4095), 1'b0);
        push_sample(uniform_sample(CHG_DONE_ACTIVE, 8191, 16383, 4095), 1'b0);
        push_sample(uniform_sample(CHG_NONE, 8191, 16383, 4095), 1'b0);
        push_sample(uniform_sample(CHG_ACTIVE, 0, 1, 1), 1'b0);

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            settle();
            case (ph % 4)
                0, 3:
                begin
                    full = 64'($urandom_range(100000000, 32'hFFFF_FFFF));
                    low  = full / 100 * $urandom_range(10, 60);
                    high = (ph % 4 == 0) ? low + full / 100 * $urandom_range(0, 40)
                                         : full / 100 * $urandom_range(0, 60);
                end
                1:
                begin
                    full = 64'(any_reg_value());
                    low  = 64'(any_reg_value());
                    high = 64'(any_reg_value());
                end
                default:
                begin
                    full = $urandom_range(0, 1) ? 64'(REG_ALL_ONES) : 64'd0;
                    low  = $urandom_range(0, 1) ? 64'(REG_ALL_ONES) : 64'd0;
                    high = $urandom_range(0, 1) ? 64'(REG_ALL_ONES) : 64'd0;
                end
            endcase
            write_register(REG_FULL_CAPACITY, full[REG_W-1:0]);
            write_register(REG_LOW_THRESHOLD, low[REG_W-1:0]);
            write_register(REG_HIGH_THRESHOLD, high[REG_W-1:0]);
            if ($urandom_range(0, 2) == 0)
            begin
                write_register(REG_SPARE, any_reg_value());
            end
            sender_idles   = (ph % 4 != 3);
            receiver_idles = (ph % 3 != 2);
            charge_pct     = $urandom_range(10, 60);
            pcur_ceiling   = (ph % 2 == 1) ? 4095 : $urandom_range(63, 1023);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                push_sample(random_sample(charge_pct, pcur_ceiling), $urandom_range(0, 39) == 0);
            end
        end

        settle();
        if (failures == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

### files.f
sv/beg_pkg.sv
sv/beg_stream_if.sv
sv/beg_panel_lane.sv
sv/beg_drain_lane.sv
sv/beg_merge.sv
sv/battery_energy_gauge_unit.sv
test/testbench.sv
